FILE: hdl/morton_order_sorter_defines.svh
// Assertion macros for the Morton order sorter.
// Included by the modules that carry assertions; needs clk and rst_n in scope.
`ifndef MORTON_ORDER_SORTER_DEFINES_SVH
`define MORTON_ORDER_SORTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define MOS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MOS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define MOS_ASSERT(label, prop, msg)
`define MOS_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

FILE: hdl/mos_pkg.sv
// Shared types, codes and helpers for the Morton order sorter.
// No dependencies.
package mos_pkg;

    localparam int MAX_PARTICLES_DEF = 256;
    localparam int GRID_BITS_DEF     = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int CFG_IDX_W         = 4;
    localparam int CFG_DATA_W        = 48;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BOUND   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_BOUND = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE      = 4'd3;

    typedef struct packed {
        logic [31:0] left_bound;
        logic [31:0] bottom_bound;
        logic [47:0] x_scale;
        logic [47:0] y_scale;
    } mos_cfg_t;

    // word handed from front to back
    typedef struct packed {
        logic        op;
        logic [63:0] code;
    } mos_item_t;

    // one stored entry
    typedef struct packed {
        logic [63:0] code;
        logic [7:0]  idx;
    } mos_entry_t;

    // x on even bits, y on odd bits
    function automatic logic [63:0] interleave(input logic [31:0] gx, input logic [31:0] gy);
        logic [63:0] code;
        code = '0;
        for (int i = 0; i < 32; i++) begin
            code[2*i]   = gx[i];
            code[2*i+1] = gy[i];
        end
        return code;
    endfunction

endpackage

FILE: hdl/morton_order_sorter.sv
// Morton order sorter top level: register file, front end, queue, back end.
// Depends on mos_pkg, mos_front, mos_queue and mos_back.
//
// Loads map a signed Q16.16 position to grid coordinates per axis,
// ((pos - bound) * scale) >> 32 clamped to 0..2^GRID_BITS-1, interleave
// them into a 64-bit Morton code (x on even bits, y on odd bits) and insert
// the code with its arrival index into a store held in descending order.
// Fetch pops the smallest code; equal codes leave in load order. Every word
// in (op 0 load, op 1 fetch) gives exactly one word out. A load into a full
// store returns status 1 with the refused code; a fetch from an empty store
// returns status 2. Arrival indices count modulo 256 and restart at zero
// when a fetch empties the store.
// Timing: the front end is a two-stage pipeline (offset, then the four
// scale partial products) feeding a four-word queue. The back end works one
// word at a time through a single-port sorted memory: a fetch reads the top
// entry; a load moves each entry whose code is less than or equal to the
// new one up a slot, then writes the new entry where a larger entry or slot
// zero stops the walk. The insertion walk sets the sustained rate. A load's
// result word is registered at the start of its walk and waits there on
// out_stall while the walk goes on; the back end takes its next word only
// once that result has left. Registers are written through cfg_we/cfg_index/
// cfg_data (0 left_bound, 1 bottom_bound, 2 x_scale, 3 y_scale) by the user
// only while idle, which the block does not enforce; other indices are
// ignored. No clearing pass is needed after reset.
module morton_order_sorter #(
    parameter int MAX_PARTICLES = mos_pkg::MAX_PARTICLES_DEF,
    parameter int GRID_BITS     = mos_pkg::GRID_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mos_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [7:0]                     particle_index,
    output logic [63:0]                    morton_code
);
    import mos_pkg::*;

    mos_cfg_t   cfg_reg;
    logic       fq_valid, fq_ready, qb_valid, qb_pop;
    mos_item_t  fq_item, qb_item;

    // configuration registers; bounds keep the low 32 bits of the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_bound   <= '0;
            cfg_reg.bottom_bound <= '0;
            cfg_reg.x_scale      <= 48'h0001_0000_0000;
            cfg_reg.y_scale      <= 48'h0001_0000_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEFT_BOUND:   cfg_reg.left_bound   <= cfg_data[31:0];
                CFG_BOTTOM_BOUND: cfg_reg.bottom_bound <= cfg_data[31:0];
                CFG_X_SCALE:      cfg_reg.x_scale      <= cfg_data;
                CFG_Y_SCALE:      cfg_reg.y_scale      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mos_front #(
        .GRID_BITS (GRID_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    mos_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop        (qb_pop),
        .pop_item   (qb_item)
    );

    mos_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (qb_valid),
        .q_pop          (qb_pop),
        .q_item         (qb_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .particle_index (particle_index),
        .morton_code    (morton_code)
    );

endmodule

FILE: hdl/mos_front.sv
// Front end: offsets, scale multiplies, saturation and bit interleave.
// Depends on mos_pkg.
module mos_front #(
    parameter int GRID_BITS = mos_pkg::GRID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mos_pkg::mos_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    output logic                q_valid,
    input  logic                q_ready,
    output mos_pkg::mos_item_t  q_item
);
    import mos_pkg::*;

    localparam logic [48:0] TOP = (49'd1 << GRID_BITS) - 49'd1;

    logic        v1_reg, v1_next, v2_reg, v2_next;
    logic        op1_reg, op2_reg;
    logic [31:0] dx_reg, dy_reg;
    logic [63:0] pxl_reg, pyl_reg;
    logic [47:0] pxh_reg, pyh_reg;
    logic        ready1, ready2, in_acc;
    logic [32:0] dx, dy;
    logic [48:0] gx_sum, gy_sum;
    logic [31:0] gx, gy;

    assign ready2   = !v2_reg || q_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;
    assign in_acc   = in_valid && ready1;

    assign dx = {pos_x[31], pos_x} - {cfg.left_bound[31], cfg.left_bound};
    assign dy = {pos_y[31], pos_y} - {cfg.bottom_bound[31], cfg.bottom_bound};

    always_comb
    begin
        v1_next = ready1 ? in_valid : v1_reg;
        v2_next = ready2 ? v1_reg : v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // non-positive offsets clamp to grid zero
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op1_reg <= op;
            dx_reg  <= (!dx[32] && (|dx[31:0])) ? dx[31:0] : 32'd0;
            dy_reg  <= (!dy[32] && (|dy[31:0])) ? dy[31:0] : 32'd0;
        end
        if (ready2 && v1_reg)
        begin
            op2_reg <= op1_reg;
            pxl_reg <= dx_reg * cfg.x_scale[31:0];
            pxh_reg <= dx_reg * cfg.x_scale[47:32];
            pyl_reg <= dy_reg * cfg.y_scale[31:0];
            pyh_reg <= dy_reg * cfg.y_scale[47:32];
        end
    end

    assign gx_sum = {17'd0, pxl_reg[63:32]} + {1'b0, pxh_reg};
    assign gy_sum = {17'd0, pyl_reg[63:32]} + {1'b0, pyh_reg};
    assign gx     = (gx_sum > TOP) ? TOP[31:0] : gx_sum[31:0];
    assign gy     = (gy_sum > TOP) ? TOP[31:0] : gy_sum[31:0];

    assign q_valid     = v2_reg;
    assign q_item.op   = op2_reg;
    assign q_item.code = interleave(gx, gy);

endmodule

FILE: hdl/mos_queue.sv
// Short word queue between front and back ends.
// Depends on mos_pkg and the assertion macro header.
`include "morton_order_sorter_defines.svh"
module mos_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  mos_pkg::mos_item_t push_item,
    output logic               pop_valid,
    input  logic               pop,
    output mos_pkg::mos_item_t pop_item
);
    import mos_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    mos_item_t          mem_reg [QUEUE_DEPTH];
    logic [QAW-1:0]     head_reg, head_next, tail_reg, tail_next;
    logic [QCW-1:0]     count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg != QCW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[head_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        head_next  = do_pop  ? QAW'(head_reg + 1'b1) : head_reg;
        tail_next  = do_push ? QAW'(tail_reg + 1'b1) : tail_reg;
        count_next = count_reg + QCW'(do_push) - QCW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[tail_reg] <= push_item;
        end
    end

    `MOS_ASSERT(a_q_count, count_reg <= QCW'(QUEUE_DEPTH), "queue count over depth")
    `MOS_ASSERT(a_q_ptrs, (count_reg == '0 || count_reg == QCW'(QUEUE_DEPTH)) || (head_reg != tail_reg), "queue pointers disagree with count")

endmodule

FILE: hdl/mos_back.sv
// Back end: sorted store in a memory, insertion walk, fetch and result register.
// Depends on mos_pkg and the assertion macro header.
`include "morton_order_sorter_defines.svh"
module mos_back #(
    parameter int MAX_PARTICLES = mos_pkg::MAX_PARTICLES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  mos_pkg::mos_item_t q_item,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [7:0]         particle_index,
    output logic [63:0]        morton_code
);
    import mos_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int OW = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_LOAD_RD  = 4'b0010,
        S_LOAD_CMP = 4'b0100,
        S_FETCH    = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [OW-1:0]     occ_reg, occ_next, j_reg, j_next, occ_m1, j_m1;
    logic [7:0]        arr_reg, arr_next;
    mos_entry_t        new_reg, new_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [7:0]        index_reg, index_next;
    logic [63:0]       code_reg, code_next;
    logic              out_free, out_load;

    mos_entry_t        store [MAX_PARTICLES];
    mos_entry_t        rdata_reg;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    mos_entry_t        mem_wdata;

    assign out_free = !out_valid_reg || !out_stall;
    assign occ_m1   = occ_reg - OW'(1);
    assign j_m1     = j_reg - OW'(1);

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        j_next         = j_reg;
        arr_next       = arr_reg;
        new_next       = new_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        status_next    = ST_OK;
        index_next     = '0;
        code_next      = '0;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = new_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_item.op == OP_LOAD)
                    begin
                        out_valid_next = 1'b1;
                        out_load       = 1'b1;
                        code_next      = q_item.code;
                        if (occ_reg == OW'(MAX_PARTICLES))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            new_next.code = q_item.code;
                            new_next.idx  = arr_reg;
                            j_next        = occ_reg;
                            occ_next      = occ_reg + OW'(1);
                            arr_next      = arr_reg + 8'd1;
                            state_next    = S_LOAD_RD;
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_load       = 1'b1;
                        status_next    = ST_EMPTY;
                    end
                    else
                    begin
                        // smallest code sits at the top of the occupied range
                        mem_re     = 1'b1;
                        mem_raddr  = occ_m1[AW-1:0];
                        occ_next   = occ_m1;
                        if (occ_m1 == '0)
                        begin
                            arr_next = '0;
                        end
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                out_valid_next = 1'b1;
                out_load       = 1'b1;
                index_next     = rdata_reg.idx;
                code_next      = rdata_reg.code;
                state_next     = S_IDLE;
            end
            S_LOAD_RD:
            begin
                if (j_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = j_m1[AW-1:0];
                    state_next = S_LOAD_CMP;
                end
            end
            S_LOAD_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                // equal codes stay above the newcomer so they leave first
                if (rdata_reg.code <= new_reg.code)
                begin
                    mem_wdata  = rdata_reg;
                    j_next     = j_m1;
                    state_next = S_LOAD_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            j_reg         <= '0;
            arr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            j_reg         <= j_next;
            arr_reg       <= arr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        if (out_load)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            code_reg   <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store[mem_raddr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign particle_index = index_reg;
    assign morton_code    = code_reg;

    `MOS_ASSERT(a_occ_bound, occ_reg <= OW'(MAX_PARTICLES), "occupancy over capacity")
    `MOS_ASSERT(a_state_hot, $onehot(state_reg), "state not one-hot")
    `MOS_ASSERT(a_arrival_empty, occ_reg != '0 || arr_reg == '0, "arrival count not cleared on empty store")
    `MOS_ASSERT(a_walk_bound, state_reg == S_IDLE || state_reg == S_FETCH || j_reg < occ_reg, "insertion slot outside store")
    `MOS_ASSERT_NEXT(a_fetch_out, state_reg == S_FETCH, out_valid_reg && status_reg == ST_OK, "fetch result missing")

endmodule
